// ===== src/lkvc_pkg.sv =====
// Shared constants, codes and transaction types for the LRU key-value cache.
`default_nettype none
package lkvc_pkg;

  // Built table size and the widths that follow from it.
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths.
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int LIMIT_W = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

  // Request commands.
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef struct packed {
    logic                      command;
    logic signed [KEY_W-1:0]   key;
    logic signed [VALUE_W-1:0] value;
  } lkvc_req_t;

  typedef struct packed {
    logic                      found;
    logic signed [VALUE_W-1:0] read_value;
  } lkvc_resp_t;

endpackage
`default_nettype wire

// ===== src/lkvc_in_if.sv =====
// Request channel: valid/ready handshake carrying command, key and value.
`default_nettype none
interface lkvc_in_if;
  import lkvc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      command;
  logic signed [KEY_W-1:0]   key;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output command, output key, output value, input ready);
  modport sink   (input valid, input command, input key, input value, output ready);
endinterface
`default_nettype wire

// ===== src/lkvc_out_if.sv =====
// Result channel: valid/ready handshake carrying the found flag and read value.
`default_nettype none
interface lkvc_out_if;
  import lkvc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      found;
  logic signed [VALUE_W-1:0] read_value;

  modport source (output valid, output found, output read_value, input ready);
  modport sink   (input valid, input found, input read_value, output ready);
endinterface
`default_nettype wire

// ===== src/lkvc_table.sv =====
// Fully associative entry table with parallel lookup and recency-rank update.
`default_nettype none
module lkvc_table (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 req_en,
  input  wire lkvc_pkg::lkvc_req_t                  req,
  input  wire logic [lkvc_pkg::LIMIT_W-1:0]         limit,
  output lkvc_pkg::lkvc_resp_t                      resp
);
  import lkvc_pkg::*;

  logic [CAPACITY-1:0]       valid_r, valid_nxt;
  logic [KEY_W-1:0]          key_r    [CAPACITY];
  logic [KEY_W-1:0]          key_nxt  [CAPACITY];
  logic [VALUE_W-1:0]        value_r  [CAPACITY];
  logic [VALUE_W-1:0]        value_nxt[CAPACITY];
  logic [IDX_W-1:0]          rank_r   [CAPACITY];
  logic [IDX_W-1:0]          rank_nxt [CAPACITY];
  logic [CNT_W-1:0]          in_use_r, in_use_nxt;

  logic [CAPACITY-1:0]       match;
  logic                      hit;
  logic [IDX_W-1:0]          hit_rank;
  logic [VALUE_W-1:0]        hit_value;
  logic [CNT_W-1:0]          lim_eff;
  logic                      put_miss;
  logic                      full;
  logic [CNT_W-1:0]          oldest_rank;
  logic [CAPACITY-1:0]       evict_mask;
  logic [CAPACITY-1:0]       valid_ae;
  logic [CAPACITY-1:0]       free_mask;
  logic [CAPACITY-1:0]       new_oh;

  // Limit clamped into 1..CAPACITY.
  always_comb begin
    if (limit == '0) begin
      lim_eff = CNT_W'(1);
    end else if (32'(limit) > CAPACITY) begin
      lim_eff = CNT_W'(CAPACITY);
    end else begin
      lim_eff = CNT_W'(limit);
    end
  end

  // Lookup. Valid keys are unique, so at most one match bit is set.
  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = valid_r[i] && (key_r[i] == req.key);
      hit_rank  |= match[i] ? rank_r[i] : '0;
      hit_value |= match[i] ? value_r[i] : '0;
    end
    hit = |match;
  end

  // Valid ranks are always 0..in_use-1, so the least recent entry holds in_use-1.
  assign put_miss    = (req.command == CMD_PUT) && !hit;
  assign full        = (in_use_r >= lim_eff);
  assign oldest_rank = CNT_W'(in_use_r - CNT_W'(1));

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      evict_mask[i] = put_miss && full && valid_r[i] &&
                      (CNT_W'(rank_r[i]) == oldest_rank);
    end
  end

  assign valid_ae  = valid_r & ~evict_mask;
  assign free_mask = ~valid_ae;
  assign new_oh    = free_mask & (~free_mask + CAPACITY'(1));

  always_comb begin
    valid_nxt  = valid_r;
    in_use_nxt = in_use_r;
    for (int i = 0; i < CAPACITY; i++) begin
      key_nxt[i]   = key_r[i];
      value_nxt[i] = value_r[i];
      rank_nxt[i]  = rank_r[i];
    end
    if (req_en && hit) begin
      // Hit on get or put: entries more recent than the hit move back one rank.
      for (int i = 0; i < CAPACITY; i++) begin
        if (match[i]) begin
          rank_nxt[i] = '0;
          if (req.command == CMD_PUT) begin
            value_nxt[i] = req.value;
          end
        end else if (valid_r[i] && (rank_r[i] < hit_rank)) begin
          rank_nxt[i] = IDX_W'(rank_r[i] + 1'b1);
        end
      end
    end else if (req_en && put_miss) begin
      // Insert as most recent after the optional eviction.
      for (int i = 0; i < CAPACITY; i++) begin
        if (new_oh[i]) begin
          key_nxt[i]   = req.key;
          value_nxt[i] = req.value;
          rank_nxt[i]  = '0;
        end else if (valid_ae[i]) begin
          rank_nxt[i] = IDX_W'(rank_r[i] + 1'b1);
        end
      end
      valid_nxt  = valid_ae | new_oh;
      in_use_nxt = (|evict_mask) ? in_use_r : CNT_W'(in_use_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      in_use_r <= '0;
    end else begin
      valid_r  <= valid_nxt;
      in_use_r <= in_use_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      key_r[i]   <= key_nxt[i];
      value_r[i] <= value_nxt[i];
      rank_r[i]  <= rank_nxt[i];
    end
  end

  assign resp.found      = hit;
  assign resp.read_value = ((req.command == CMD_GET) && hit) ? hit_value : '0;

endmodule
`default_nettype wire

// ===== src/lru_key_value_cache_unit.sv =====
// Top level of the LRU key-value cache: handshake registers around the entry table.
//
// Usage:
//   in_chan carries one request per transaction: a command (get or put), a
//   key and a value. out_chan returns exactly one result per request, in
//   order: a found flag and, on a get hit, the stored value (zero otherwise).
//   cfg_wr_en/cfg_wr_data set the capacity limit; write it only while no
//   request is in flight.
//   A request accepted into the input register is looked up and applied to
//   the table when it is processed, and its result is loaded into the result
//   register, from which it is offered on out_chan.
//   Throughput: one request per cycle unless out_chan stalls. Lookup over all
//   16 entries, eviction choice and recency-rank update are combinational.
//   Reset clears all valid marks and the occupancy count at once and sets the
//   capacity limit to 16; there is no clearing pass, so in_chan is ready
//   as soon as reset is released.
//   When the receiver stalls, the result register holds its transaction and
//   one more request waits in the input register; in_chan.ready then drops
//   until out_chan moves again.
`default_nettype none
module lru_key_value_cache_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  lkvc_in_if.sink                           in_chan,
  lkvc_out_if.source                        out_chan,
  input  wire logic                         cfg_wr_en,
  input  wire logic [lkvc_pkg::LIMIT_W-1:0] cfg_wr_data
);
  import lkvc_pkg::*;

  logic               req_valid_r;
  lkvc_req_t          req_r;
  logic               out_valid_r;
  lkvc_resp_t         out_resp_r;
  logic [LIMIT_W-1:0] limit_r;
  lkvc_resp_t         table_resp;
  logic               proc_en;
  logic               in_take;

  // The held request is processed whenever the result register is free or
  // is being emptied in this cycle.
  assign proc_en        = req_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = !req_valid_r || proc_en;
  assign in_take        = in_chan.valid && in_chan.ready;

  lkvc_table u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .req_en (proc_en),
    .req    (req_r),
    .limit  (limit_r),
    .resp   (table_resp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      limit_r     <= LIMIT_RESET;
    end else begin
      if (in_take) begin
        req_valid_r <= 1'b1;
      end else if (proc_en) begin
        req_valid_r <= 1'b0;
      end
      if (proc_en) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r.command <= in_chan.command;
      req_r.key     <= in_chan.key;
      req_r.value   <= in_chan.value;
    end
    if (proc_en) begin
      out_resp_r <= table_resp;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.found      = out_resp_r.found;
  assign out_chan.read_value = out_resp_r.read_value;

endmodule
`default_nettype wire
